>>> sv/rth_pkg.sv
// rth_pkg: widths, constants and stage types for the rgb to hsl converter
// no dependencies; used by every other file of the block
package rth_pkg;

    localparam int CH_W     = 8;   // one color channel
    localparam int HUE_W    = 16;
    localparam int SAT_W    = 17;
    localparam int LSUM_W   = 9;
    localparam int Q_W      = 17;  // quotient bits of each divider
    localparam int DV_W     = 11;  // dividend and divisor width (up to 6 * 255)
    localparam int RM_W     = 12;  // partial remainder, one bit of headroom for the shift
    localparam int STEPS_PER_STAGE = 4;
    localparam int DIV_STAGES = (Q_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    // front stage result handed to the dividers
    typedef struct packed {
        logic [DV_W-1:0]   hue_num;
        logic [DV_W-1:0]   hue_den;
        logic [DV_W-1:0]   sat_num;
        logic [DV_W-1:0]   sat_den;
        logic [LSUM_W-1:0] lsum;
        logic              grey;
    } t_front;

endpackage

>>> sv/rth_if.sv
// rth_pix_if and rth_hsl_if: valid/ready channels for pixels and results
// depends on rth_pkg for field widths
interface rth_pix_if import rth_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    modport source (output valid, red, green, blue, input ready);
    modport sink (input valid, red, green, blue, output ready);
endinterface

interface rth_hsl_if import rth_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [HUE_W-1:0]  hue;
    logic [SAT_W-1:0]  saturation;
    logic [LSUM_W-1:0] lightness_sum;
    modport source (output valid, hue, saturation, lightness_sum, input ready);
    modport sink (input valid, hue, saturation, lightness_sum, output ready);
endinterface

>>> sv/rth_front.sv
// rth_front: max/min search, lightness sum and divider operands, one register stage
// depends on rth_pkg
module rth_front import rth_pkg::*; (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [CH_W-1:0] i_red,
    input  logic [CH_W-1:0] i_green,
    input  logic [CH_W-1:0] i_blue,
    output t_front          o_front
);

    t_front          n_front;
    t_front          r_front;
    logic [CH_W-1:0] mx;
    logic [CH_W-1:0] mn;
    logic [CH_W-1:0] d;
    logic [DV_W-1:0] dx;
    logic [DV_W-1:0] num;

    // channel extremes and operands
    always_comb begin
        mx = (i_red > i_green) ? i_red : i_green;
        if (i_blue > mx) begin
            mx = i_blue;
        end
        mn = (i_red < i_green) ? i_red : i_green;
        if (i_blue < mn) begin
            mn = i_blue;
        end
        d  = mx - mn;
        dx = DV_W'(d);
        // six-sector numerator, ties resolved red then green
        if (i_red == mx) begin
            num = (i_green == mn) ? (DV_W'(5) * dx + DV_W'(mx - i_blue))
                                  : (dx - DV_W'(mx - i_green));
        end else if (i_green == mx) begin
            num = (i_blue == mn) ? (dx + DV_W'(mx - i_red))
                                 : (DV_W'(3) * dx - DV_W'(mx - i_blue));
        end else begin
            num = (i_red == mn) ? (DV_W'(3) * dx + DV_W'(mx - i_green))
                                : (DV_W'(5) * dx - DV_W'(mx - i_red));
        end
        n_front.lsum    = LSUM_W'(mx) + LSUM_W'(mn);
        n_front.hue_num = num;
        n_front.hue_den = (dx << 2) + (dx << 1);
        n_front.sat_num = dx;
        n_front.sat_den = (n_front.lsum <= LSUM_W'(255)) ? DV_W'(n_front.lsum)
                        : DV_W'(LSUM_W'(510) - n_front.lsum);
        n_front.grey    = (d == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_front <= n_front;
        end
    end

    assign o_front = r_front;

endmodule

>>> sv/rth_div.sv
// rth_div: pipelined restoring divider, num * 2^16 / den with num <= den
// depends on rth_pkg; up to STEPS_PER_STAGE quotient bits per register stage
module rth_div import rth_pkg::*; (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [DV_W-1:0] i_num,
    input  logic [DV_W-1:0] i_den,
    output logic [Q_W-1:0]  o_quo
);

    logic [RM_W-1:0] r_rem [DIV_STAGES];
    logic [Q_W-1:0]  r_quo [DIV_STAGES];
    logic [DV_W-1:0] r_den [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [RM_W-1:0] rem_in;
        logic [Q_W-1:0]  quo_in;
        logic [RM_W-1:0] n_rem;
        logic [Q_W-1:0]  n_quo;
        logic [DV_W-1:0] den;

        // stage operands, from the ports or the previous stage
        if (s == 0) begin : g_head
            assign rem_in = RM_W'(i_num);
            assign quo_in = '0;
            assign den    = i_den;
        end else begin : g_body
            assign rem_in = r_rem[s-1];
            assign quo_in = r_quo[s-1];
            assign den    = r_den[s-1];
        end

        // up to STEPS_PER_STAGE shift-subtract steps per stage
        always_comb begin
            n_rem = rem_in;
            n_quo = quo_in;
            for (int k = 0; k < STEPS_PER_STAGE; k++) begin
                if (s * STEPS_PER_STAGE + k < Q_W) begin
                    if (s * STEPS_PER_STAGE + k != 0) begin
                        n_rem = n_rem << 1;
                    end
                    if (n_rem >= RM_W'(den)) begin
                        n_rem = n_rem - RM_W'(den);
                        n_quo = {n_quo[Q_W-2:0], 1'b1};
                    end else begin
                        n_quo = {n_quo[Q_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_quo[s] <= n_quo;
                r_den[s] <= den;
            end
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];

endmodule

>>> sv/rgb_to_hsl_converter.sv
// rgb_to_hsl_converter: 8-bit rgb pixel to fixed-point hue, saturation, lightness sum
// result passes through the front stage, 5 divider stages
// (4, 4, 4, 4 and 1 quotient bits) and the output register
// throughput one pixel per cycle; the whole pipeline holds when the output is stalled
// synchronous active-low reset clears the valid bits only; depends on rth_pkg, rth_if,
// rth_front, rth_div
module rgb_to_hsl_converter import rth_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rth_pix_if.sink   i_pix,
    rth_hsl_if.source o_hsl
);

    logic              adv;
    t_front            front;
    logic [Q_W-1:0]    hue_q;
    logic [Q_W-1:0]    sat_q;
    logic              r_fvld;
    logic              r_dvld [DIV_STAGES];
    logic [LSUM_W-1:0] r_lsum [DIV_STAGES];
    logic              r_grey [DIV_STAGES];
    logic              r_ovld;
    logic [HUE_W-1:0]  r_hue;
    logic [SAT_W-1:0]  r_sat;
    logic [LSUM_W-1:0] r_olsum;

    // pipeline moves whenever the output register is free or being emptied
    assign adv         = !r_ovld || o_hsl.ready;
    assign i_pix.ready = adv;

    rth_front u_front (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_red   (i_pix.red),
        .i_green (i_pix.green),
        .i_blue  (i_pix.blue),
        .o_front (front)
    );

    rth_div u_hue_div (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (front.hue_num),
        .i_den (front.hue_den),
        .o_quo (hue_q)
    );

    rth_div u_sat_div (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num (front.sat_num),
        .i_den (front.sat_den),
        .o_quo (sat_q)
    );

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvld <= 1'b0;
            r_ovld <= 1'b0;
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_dvld[s] <= 1'b0;
            end
        end else if (adv) begin
            r_fvld    <= i_pix.valid;
            r_dvld[0] <= r_fvld;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_dvld[s] <= r_dvld[s-1];
            end
            r_ovld <= r_dvld[DIV_STAGES-1];
        end
    end

    // sideband beside the dividers and output register
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_lsum[0] <= front.lsum;
            r_grey[0] <= front.grey;
            for (int s = 1; s < DIV_STAGES; s++) begin
                r_lsum[s] <= r_lsum[s-1];
                r_grey[s] <= r_grey[s-1];
            end
            // grey or black gives zero hue and saturation; a full turn wraps to 0
            r_hue   <= r_grey[DIV_STAGES-1] ? '0 : hue_q[HUE_W-1:0];
            r_sat   <= r_grey[DIV_STAGES-1] ? '0 : SAT_W'(sat_q);
            r_olsum <= r_lsum[DIV_STAGES-1];
        end
    end

    assign o_hsl.valid         = r_ovld;
    assign o_hsl.hue           = r_hue;
    assign o_hsl.saturation    = r_sat;
    assign o_hsl.lightness_sum = r_olsum;

endmodule
